// ----- sv/bsds_pkg.sv -----
// ----------------------------------------------------------------------------
// bsds_pkg
// Shared types and constants of the byte stream delimiter splitter.
// ----------------------------------------------------------------------------
package bsds_pkg;

  localparam int LEN_W    = 4;
  localparam int DELIM_W  = 64;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES  = 1'b1;

  localparam logic [LEN_W-1:0]   DELIM_LENGTH_RESET = 4'd1;
  localparam logic [DELIM_W-1:0] DELIM_BYTES_RESET  = 64'd10;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       source_done;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       section_end;
    logic       source_end;
    logic       last;
  } out_word_t;

  // marker that closes a job, if any
  typedef struct packed {
    logic section_end;
    logic source_end;
  } job_ctl_t;

endpackage

// ----- sv/bsds_if.sv -----
// ----------------------------------------------------------------------------
// bsds_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface bsds_in_if;
  logic               valid;
  logic               ready;
  bsds_pkg::in_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface bsds_out_if;
  logic                valid;
  logic                ready;
  bsds_pkg::out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- sv/bsds_front.sv -----
// ----------------------------------------------------------------------------
// bsds_front
// Holds config and candidate bytes, matches each word against the delimiter
// and issues at most one job (bytes to emit plus optional marker) per word.
// ----------------------------------------------------------------------------
module bsds_front #(
  parameter int MAX_DELIM = 8,
  localparam int IW = $clog2(MAX_DELIM),
  localparam int CW = $clog2(MAX_DELIM + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bsds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bsds_pkg::CFG_DATA_W-1:0]   cfg_data,
  bsds_in_if.sink                           in_ch,
  output logic                              job_valid,
  input  logic                              job_ready,
  output logic [MAX_DELIM*8-1:0]            job_bytes,
  output logic [CW-1:0]                     job_emit,
  output bsds_pkg::job_ctl_t                job_ctl
);

  logic [bsds_pkg::LEN_W-1:0]   delim_length;
  logic [bsds_pkg::DELIM_W-1:0] delim_bytes;
  logic [7:0]                   held [MAX_DELIM-1];
  logic [7:0]                   held_next [MAX_DELIM-1];
  logic [IW-1:0]                hc;
  logic [IW-1:0]                hc_next;

  logic [7:0]     cand [MAX_DELIM];
  logic [7:0]     win [MAX_DELIM];
  logic [7:0]     dbyte [MAX_DELIM];
  logic [MAX_DELIM:0] m;
  logic [CW-1:0]  len;
  logic [CW-1:0]  dlen;
  logic [IW-1:0]  k;
  logic           full;
  logic           accept;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = job_ready;
  assign len         = CW'(hc) + CW'(1);

  always_comb begin
    if (delim_length == '0) begin
      dlen = CW'(1);
    end else if (delim_length > bsds_pkg::LEN_W'(MAX_DELIM)) begin
      dlen = CW'(MAX_DELIM);
    end else begin
      dlen = CW'(delim_length);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_DELIM; i++) begin
      dbyte[i] = delim_bytes[8*i +: 8];
      cand[i]  = '0;
    end
    for (int i = 0; i < MAX_DELIM - 1; i++) begin
      if (IW'(i) < hc) begin
        cand[i] = held[i];
      end
    end
    cand[hc] = in_ch.data.in_byte;
    // newest byte first
    for (int t = 0; t < MAX_DELIM; t++) begin
      win[t] = (IW'(t) <= hc) ? cand[hc - IW'(t)] : 8'h00;
    end
    // m[n]: the last n candidate bytes equal the first n delimiter bytes
    m[0] = 1'b1;
    for (int n = 1; n <= MAX_DELIM; n++) begin
      m[n] = (CW'(n) <= len);
      for (int j = 0; j < n; j++) begin
        if (win[n-1-j] != dbyte[j]) begin
          m[n] = 1'b0;
        end
      end
    end
    full = (dlen <= len) && m[dlen];
    k = '0;
    for (int n = 1; n < MAX_DELIM; n++) begin
      if (CW'(n) < dlen && m[n]) begin
        k = IW'(n);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_DELIM - 1; j++) begin
      held_next[j] = held[j];
    end
    job_ctl = '0;
    if (in_ch.data.source_done) begin
      job_emit           = CW'(hc);
      job_ctl.source_end = 1'b1;
      hc_next            = '0;
    end else if (full) begin
      job_emit            = len - dlen;
      job_ctl.section_end = 1'b1;
      hc_next             = '0;
    end else begin
      job_emit = len - CW'(k);
      hc_next  = k;
      for (int j = 0; j < MAX_DELIM - 1; j++) begin
        held_next[j] = cand[IW'(len - CW'(k) + CW'(j))];
      end
    end
    for (int i = 0; i < MAX_DELIM; i++) begin
      job_bytes[8*i +: 8] = cand[i];
    end
    job_valid = accept && (job_emit != '0 || job_ctl.section_end || job_ctl.source_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delim_length <= bsds_pkg::DELIM_LENGTH_RESET;
      delim_bytes  <= bsds_pkg::DELIM_BYTES_RESET;
    end else if (cfg_we) begin
      if (cfg_index == bsds_pkg::REG_DELIM_LENGTH) begin
        delim_length <= cfg_data[bsds_pkg::LEN_W-1:0];
      end else if (cfg_index == bsds_pkg::REG_DELIM_BYTES) begin
        delim_bytes <= cfg_data[bsds_pkg::DELIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hc <= '0;
    end else if (accept) begin
      hc <= hc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < MAX_DELIM - 1; j++) begin
        held[j] <= held_next[j];
      end
    end
  end

  a_hc_range: assert property (@(posedge clk) disable iff (rst)
    CW'(hc) < CW'(MAX_DELIM))
    else $error("held count out of range");

  a_src_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.data.source_done |=> hc == '0)
    else $error("held bytes kept after source end");

endmodule

// ----- sv/bsds_queue.sv -----
// ----------------------------------------------------------------------------
// bsds_queue
// Small register FIFO between the matcher and the result sequencer.
// ----------------------------------------------------------------------------
module bsds_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int NW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;
  logic             push;
  logic             pop;

  assign in_ready  = count != NW'(DEPTH);
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(DEPTH))
    else $error("queue overfilled");

endmodule

// ----- sv/bsds_back.sv -----
// ----------------------------------------------------------------------------
// bsds_back
// Plays out one job as result words: the data bytes in order, then the
// marker if any, with last on the final word.
// ----------------------------------------------------------------------------
module bsds_back #(
  parameter int MAX_DELIM = 8,
  localparam int IW = $clog2(MAX_DELIM),
  localparam int CW = $clog2(MAX_DELIM + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   job_valid,
  output logic                   job_ready,
  input  logic [MAX_DELIM*8-1:0] job_bytes,
  input  logic [CW-1:0]          job_emit,
  input  bsds_pkg::job_ctl_t     job_ctl,
  bsds_out_if.source             out_ch
);

  logic                   busy;
  logic [MAX_DELIM*8-1:0] bytes_r;
  logic [CW-1:0]          emit_r;
  bsds_pkg::job_ctl_t     ctl_r;
  logic [CW-1:0]          idx;
  logic [CW-1:0]          total;
  logic                   is_data;
  logic                   is_last;
  logic                   out_acc;

  assign total   = emit_r + CW'(ctl_r.section_end || ctl_r.source_end);
  assign is_data = idx < emit_r;
  assign is_last = idx == total - CW'(1);
  assign out_acc = out_ch.valid && out_ch.ready;
  assign job_ready = !busy || (out_acc && is_last);

  always_comb begin
    out_ch.valid            = busy;
    out_ch.data.out_byte    = is_data ? bytes_r[{idx[IW-1:0], 3'b000} +: 8] : 8'h00;
    out_ch.data.byte_valid  = is_data;
    out_ch.data.section_end = !is_data && ctl_r.section_end;
    out_ch.data.source_end  = !is_data && ctl_r.source_end;
    out_ch.data.last        = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (job_ready) begin
      busy <= job_valid;
      idx  <= '0;
    end else if (out_acc) begin
      idx <= idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      bytes_r <= job_bytes;
      emit_r  <= job_emit;
      ctl_r   <= job_ctl;
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    busy |-> (total != '0) && (idx < total))
    else $error("result index past end of job");

  a_no_double_marker: assert property (@(posedge clk) disable iff (rst)
    busy |-> !(ctl_r.section_end && ctl_r.source_end))
    else $error("job carries both markers");

endmodule

// ----- sv/byte_stream_delimiter_splitter_top.sv -----
// ----------------------------------------------------------------------------
// byte_stream_delimiter_splitter_top
// Splits a byte stream into sections at a configurable 1..MAX_DELIM byte
// delimiter.
// A word's job is registered in the job queue, then in the sequencer.
// Throughput: one result word per cycle from the sequencer while out_ch.ready
// is high; each accepted word causes 0 to MAX_DELIM result words.
// The 2-entry job queue lets input run ahead while results drain.
// Reset: rst (sync) clears held count, queue and sequencer; config to defaults.
// ----------------------------------------------------------------------------
module byte_stream_delimiter_splitter_top #(
  parameter int MAX_DELIM = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bsds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsds_pkg::CFG_DATA_W-1:0] cfg_data,
  bsds_in_if.sink                         in_ch,
  bsds_out_if.source                      out_ch
);

  localparam int CW = $clog2(MAX_DELIM + 1);
  localparam int JW = MAX_DELIM * 8 + CW + $bits(bsds_pkg::job_ctl_t);

  logic                   f_valid;
  logic                   f_ready;
  logic [MAX_DELIM*8-1:0] f_bytes;
  logic [CW-1:0]          f_emit;
  bsds_pkg::job_ctl_t     f_ctl;
  logic                   b_valid;
  logic                   b_ready;
  logic [JW-1:0]          b_data;

  bsds_front #(.MAX_DELIM(MAX_DELIM)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job_bytes (f_bytes),
    .job_emit  (f_emit),
    .job_ctl   (f_ctl)
  );

  bsds_queue #(.WIDTH(JW), .DEPTH(bsds_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_bytes, f_emit, f_ctl}),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_data)
  );

  bsds_back #(.MAX_DELIM(MAX_DELIM)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .job_bytes (b_data[JW-1 -: MAX_DELIM*8]),
    .job_emit  (b_data[$bits(bsds_pkg::job_ctl_t) +: CW]),
    .job_ctl   (bsds_pkg::job_ctl_t'(b_data[$bits(bsds_pkg::job_ctl_t)-1:0])),
    .out_ch    (out_ch)
  );

endmodule

// ----- test/tb_byte_stream_delimiter_splitter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_stream_delimiter_splitter_top
// Self-checking bench for the byte stream delimiter splitter. A short directed
// sequence covers the delimiter corner cases, then random phases mix
// well-formed sections with partial prefixes and noise under several delimiter
// settings. Every accepted result word is checked against an in-bench model.
// ----------------------------------------------------------------------------
module tb_byte_stream_delimiter_splitter_top;

  localparam int MAX_DELIM   = 8;
  localparam int CYCLE_LIMIT = 400000;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [bsds_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bsds_pkg::CFG_DATA_W-1:0] cfg_data;

  bsds_in_if  in_ch();
  bsds_out_if out_ch();

  byte_stream_delimiter_splitter_top #(
    .MAX_DELIM(MAX_DELIM)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // model state
  logic [bsds_pkg::LEN_W-1:0]   model_len;
  logic [bsds_pkg::DELIM_W-1:0] model_delim;
  logic [7:0]                   held_m [MAX_DELIM-1];
  int                           held_n;

  bsds_pkg::in_word_t  stim_words[$];
  bsds_pkg::out_word_t expected_out[$];

  int                 mismatches;
  int                 cycles;
  int                 in_idle_pct;
  int                 out_idle_pct;
  int                 gap_left;
  int                 stall_left;
  logic               drv_valid;
  bsds_pkg::in_word_t drv_word;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_len();
    if (model_len == '0) return 1;
    if (model_len > MAX_DELIM) return MAX_DELIM;
    return int'(model_len);
  endfunction

  function automatic logic [7:0] delim_byte(int j);
    return model_delim[8*j +: 8];
  endfunction

  function automatic bsds_pkg::out_word_t make_word(logic [7:0] b, logic bv, logic se,
                                                    logic so);
    bsds_pkg::out_word_t r;
    r.out_byte    = b;
    r.byte_valid  = bv;
    r.section_end = se;
    r.source_end  = so;
    r.last        = 1'b0;
    return r;
  endfunction

  task automatic split_step(input bsds_pkg::in_word_t w);
    logic [7:0]          cand [MAX_DELIM];
    bsds_pkg::out_word_t res[$];
    int                  n_len;
    int                  dl;
    int                  k;
    bit                  full;
    bit                  ok;
    if (w.source_done) begin
      for (int i = 0; i < held_n; i++)
        res.push_back(make_word(held_m[i], 1'b1, 1'b0, 1'b0));
      res.push_back(make_word(8'd0, 1'b0, 1'b0, 1'b1));
      held_n = 0;
    end else begin
      for (int i = 0; i < held_n; i++) cand[i] = held_m[i];
      cand[held_n] = w.in_byte;
      n_len = held_n + 1;
      dl = eff_len();
      full = 1'b0;
      if (n_len >= dl) begin
        full = 1'b1;
        for (int j = 0; j < dl; j++)
          if (cand[n_len-dl+j] != delim_byte(j)) full = 1'b0;
      end
      if (full) begin
        for (int i = 0; i < n_len - dl; i++)
          res.push_back(make_word(cand[i], 1'b1, 1'b0, 1'b0));
        res.push_back(make_word(8'd0, 1'b0, 1'b1, 1'b0));
        held_n = 0;
      end else begin
        // fall back to the longest tail that is still a delimiter prefix
        k = (n_len < dl - 1) ? n_len : dl - 1;
        while (k > 0) begin
          ok = 1'b1;
          for (int j = 0; j < k; j++)
            if (cand[n_len-k+j] != delim_byte(j)) ok = 1'b0;
          if (ok) break;
          k--;
        end
        for (int i = 0; i < n_len - k; i++)
          res.push_back(make_word(cand[i], 1'b1, 1'b0, 1'b0));
        for (int j = 0; j < k; j++) held_m[j] = cand[n_len-k+j];
        held_n = k;
      end
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) expected_out.push_back(res[i]);
  endtask

  task automatic note_mismatch(string what, bsds_pkg::out_word_t exp_w,
                               bsds_pkg::out_word_t got_w);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected byte=%02h bv/se/so/last=%0b%0b%0b%0b, got byte=%02h %s%0b%0b%0b%0b",
               $time, what, exp_w.out_byte, exp_w.byte_valid, exp_w.section_end,
               exp_w.source_end, exp_w.last, got_w.out_byte, "bv/se/so/last=",
               got_w.byte_valid, got_w.section_end, got_w.source_end, got_w.last);
  endtask

  task automatic check_result(input bsds_pkg::out_word_t got_w);
    bsds_pkg::out_word_t exp_w;
    if (expected_out.size() == 0) begin
      note_mismatch("unexpected word", '0, got_w);
    end else begin
      exp_w = expected_out.pop_front();
      if (got_w.out_byte !== exp_w.out_byte || got_w.byte_valid !== exp_w.byte_valid ||
          got_w.section_end !== exp_w.section_end || got_w.source_end !== exp_w.source_end ||
          got_w.last !== exp_w.last)
        note_mismatch("word mismatch", exp_w, got_w);
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      drv_valid = in_ch.valid;
      drv_word  = in_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        split_step(in_ch.data);
        drv_valid = 1'b0;
      end
      if (!drv_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_words.size() > 0) begin
          if ($urandom_range(0, 99) < in_idle_pct) begin
            gap_left = $urandom_range(0, 12);
          end else begin
            drv_valid = 1'b1;
            drv_word  = stim_words.pop_front();
          end
        end
      end
      in_ch.valid <= drv_valid;
      in_ch.data  <= drv_word;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result(out_ch.data);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < out_idle_pct) begin
        stall_left = $urandom_range(0, 12);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void push_byte(logic [7:0] b);
    bsds_pkg::in_word_t w;
    w.in_byte     = b;
    w.source_done = 1'b0;
    stim_words.push_back(w);
  endfunction

  function automatic void push_done();
    bsds_pkg::in_word_t w;
    w.in_byte     = 8'($urandom);
    w.source_done = 1'b1;
    stim_words.push_back(w);
  endfunction

  task automatic write_reg(input logic [bsds_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bsds_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == bsds_pkg::REG_DELIM_LENGTH) model_len = val[bsds_pkg::LEN_W-1:0];
    else model_delim = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_len(input int len);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(0, 1)) v[63:bsds_pkg::LEN_W] = '0;
    v[bsds_pkg::LEN_W-1:0] = len[bsds_pkg::LEN_W-1:0];
    write_reg(bsds_pkg::REG_DELIM_LENGTH, v);
  endtask

  task automatic drain(input int settle);
    while (stim_words.size() != 0 || in_ch.valid || expected_out.size() != 0)
      @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  function automatic logic [7:0] mix_byte(int dl);
    if ($urandom_range(0, 2) == 0) return 8'($urandom);
    return delim_byte($urandom_range(0, dl - 1));
  endfunction

  task automatic gen_stream(input int n);
    int start;
    int dl;
    int sel;
    int cnt;
    start = stim_words.size();
    dl = eff_len();
    while (stim_words.size() - start < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        cnt = $urandom_range(0, 5);
        repeat (cnt) push_byte(mix_byte(dl));
        for (int j = 0; j < dl; j++) push_byte(delim_byte(j));
      end else if (sel < 70) begin
        cnt = (dl > 1) ? $urandom_range(1, dl - 1) : 1;
        for (int j = 0; j < cnt; j++) push_byte(delim_byte(j));
        cnt = $urandom_range(0, 2);
        repeat (cnt) push_byte(mix_byte(dl));
      end else if (sel < 90) begin
        cnt = $urandom_range(1, 4);
        repeat (cnt) push_byte(8'($urandom));
      end else begin
        push_done();
      end
    end
  endtask

  task automatic pick_delim(input int mode);
    logic [63:0] v;
    logic [7:0]  a;
    logic [7:0]  b;
    a = 8'($urandom);
    b = 8'($urandom);
    case (mode)
      0: begin
        for (int j = 0; j < 8; j++) v[8*j +: 8] = $urandom_range(0, 1) ? a : b;
      end
      1: v = {$urandom, $urandom};
      2: v = '0;
      default: v = '1;
    endcase
    write_reg(bsds_pkg::REG_DELIM_BYTES, v);
  endtask

  initial begin
    int lens [12];
    int idle_opts [4];
    lens         = '{8, 2, 0, 5, 15, 1, 3, 7, 9, 4, 6, 8};
    idle_opts    = '{0, 10, 25, 50};
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    mismatches   = 0;
    cycles       = 0;
    in_idle_pct  = 20;
    out_idle_pct = 20;
    model_len    = bsds_pkg::DELIM_LENGTH_RESET;
    model_delim  = bsds_pkg::DELIM_BYTES_RESET;
    held_n       = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default single newline delimiter
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h0A);
    push_done();
    push_byte(8'h0A);
    drain(8);

    // "aab": fallback to a shorter prefix, then end of source flushes held bytes
    write_len(3);
    write_reg(bsds_pkg::REG_DELIM_BYTES, 64'h0000_0000_0062_6161);
    push_byte(8'h61);
    push_byte(8'h61);
    push_byte(8'h61);
    push_byte(8'h62);
    push_byte(8'h61);
    push_byte(8'h78);
    push_byte(8'h61);
    push_byte(8'h61);
    push_done();
    push_byte(8'h61);
    push_byte(8'h61);
    drain(8);

    // zero length acts as one, shorter delimiter with "aa" still held
    write_len(0);
    write_reg(bsds_pkg::REG_DELIM_BYTES, {$urandom, 24'($urandom), 8'h61});
    push_byte(8'h61);
    push_byte(8'h7A);
    drain(8);

    // oversized length acts as eight
    write_len(15);
    write_reg(bsds_pkg::REG_DELIM_BYTES, 64'h0807_0605_0403_0201);
    for (int i = 1; i <= 8; i++) push_byte(8'(i));
    push_done();
    drain(8);

    for (int p = 0; p < 12; p++) begin
      if (p >= 10) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = idle_opts[$urandom_range(0, 3)];
        out_idle_pct = idle_opts[$urandom_range(0, 3)];
      end
      write_len(lens[p]);
      pick_delim((p < 4) ? p : $urandom_range(0, 3));
      gen_stream(33);
      drain(8);
    end

    drain(20);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- byte_stream_delimiter_splitter_top.f -----
sv/bsds_pkg.sv
sv/bsds_if.sv
sv/bsds_front.sv
sv/bsds_queue.sv
sv/bsds_back.sv
sv/byte_stream_delimiter_splitter_top.sv
test/tb_byte_stream_delimiter_splitter_top.sv
